// File: sv/rwlq_pkg.sv
// ============================================================================
// rwlq_pkg: shared types and constants of the reader-writer lock queue
// Slot counts, request, mode and status codes, and the cell control struct.
// ============================================================================
package rwlq_pkg;

  // Both chains are instances of the same chain module, so they share one depth.
  localparam int CHAIN_SLOTS  = 16;
  localparam int CHAIN_CW     = $clog2(CHAIN_SLOTS + 1);
  localparam int HOLDER_SLOTS = CHAIN_SLOTS;
  localparam int WAITER_SLOTS = CHAIN_SLOTS;
  localparam int MAX_RESULTS  = 16;
  localparam int BATCH_LIMIT  = (HOLDER_SLOTS < MAX_RESULTS) ? HOLDER_SLOTS : MAX_RESULTS;
  localparam int BATCH_CW     = $clog2(BATCH_LIMIT + 1);
  localparam int HCNT_W = CHAIN_CW;
  localparam int WCNT_W = CHAIN_CW;

  typedef enum logic [1:0] {
    KIND_READ    = 2'd0,
    KIND_WRITE   = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    MODE_UNLOCKED = 2'd0,
    MODE_READ     = 2'd1,
    MODE_WRITE    = 2'd2,
    MODE_BAD      = 2'd3
  } mode_t;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_HOLDER_FUL = 2'd1;
  localparam logic [1:0] ST_WAITER_FUL = 2'd2;

  // Command broadcast to every cell of a chain.
  typedef struct packed {
    logic        push;     // append at the slot equal to the count
    logic        shift;    // cell takes its right neighbor's contents
    logic        remove;   // cells at or above the first match shift
    logic        purge;    // first cell matching the key is squeezed out
    logic [31:0] key;      // identifier pushed or compared
    logic        key_wr;   // write flag that goes with a push
  } chain_cmd_t;

endpackage

// File: sv/reader_writer_lock_queue.sv
// ============================================================================
// reader_writer_lock_queue: one reader-writer lock with a FIFO of waiters
// Holder set and waiter queue are chains of slot cells that shift toward
// the head; a small sequencer grants waiters one per cycle unless the output stalls.
// ============================================================================
//
//  Channel | Direction | Payload
//  --------+-----------+-------------------------------------------------
//  in_     | sink      | tdata: txn[31:0]; tuser: kind[1:0]
//  out_    | source    | tdata: grantee[31:0]; tuser: granted_now,
//          |           |   grantee_valid, lock_mode[1:0], status[1:0]; tlast
//
// An acquire or a plain release decides and updates the chains, and its
// result then sits in the output register. A release by a non-holder
// purges one queued match per cycle and then loads its result. A release
// that hands the lock on emits one beat per grantee, one per cycle, as the
// waiter head shifts into the holder chain. Reset (rst_n low, synchronous)
// empties both chains and unlocks. A stalled output beat holds the
// sequencer; no input is accepted until the result of the previous one has
// been taken.
module reader_writer_lock_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // txn[31:0]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // grantee[31:0]
  output logic [5:0]  out_tuser,  // granted_now, grantee_valid, lock_mode[2], status[2]
  output logic        out_tlast
);
  import rwlq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PURGE = 4'b0010,
    S_GRANT = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic [31:0] key_r, key_nxt;
  logic [BATCH_CW-1:0] ng_r, ng_nxt;

  logic        ov_r, ov_nxt;
  logic [31:0] od_r, od_nxt;
  logic        og_r, og_nxt, ogv_r, ogv_nxt, ol_r, ol_nxt;
  logic [1:0]  os_r, os_nxt;

  chain_cmd_t hcmd, wcmd;
  logic [HCNT_W-1:0] hcount;
  logic [WCNT_W-1:0] wcount;
  logic [HOLDER_SLOTS-1:0][31:0] hids;
  logic [HOLDER_SLOTS-1:0]       hwrs;
  logic [WAITER_SLOTS-1:0][31:0] wids;
  logic [WAITER_SLOTS-1:0]       wwrs;
  logic hhit, hfull, whit, wfull;

  rwlq_chain u_holders (
    .clk(clk), .rst_n(rst_n), .cmd(hcmd), .count(hcount), .ids(hids),
    .wrs(hwrs), .hit(hhit), .full(hfull)
  );
  rwlq_chain u_waiters (
    .clk(clk), .rst_n(rst_n), .cmd(wcmd), .count(wcount), .ids(wids),
    .wrs(wwrs), .hit(whit), .full(wfull)
  );

  logic in_fire, out_fire, out_free;
  assign in_tready = (state_r == S_IDLE) && !ov_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign out_free  = !ov_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    key_nxt   = key_r;
    ng_nxt    = ng_r;
    ov_nxt = ov_r && !out_tready;
    od_nxt = od_r; og_nxt = og_r; ogv_nxt = ogv_r; os_nxt = os_r; ol_nxt = ol_r;
    hcmd = '0; wcmd = '0;
    hcmd.key = (state_r == S_IDLE) ? in_tdata : key_r;
    wcmd.key = hcmd.key;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt = in_tdata;
          ov_nxt = 1'b1; od_nxt = '0; og_nxt = 1'b0; ogv_nxt = 1'b0;
          os_nxt = ST_OK; ol_nxt = 1'b1;
          if (in_tuser == KIND_READ || in_tuser == KIND_WRITE) begin
            if (mode_r == MODE_UNLOCKED ||
                (in_tuser == KIND_READ && mode_r == MODE_READ && wcount == '0)) begin
              if (hfull) os_nxt = ST_HOLDER_FUL;
              else begin
                hcmd.push = 1'b1;
                og_nxt = 1'b1;
                if (mode_r == MODE_UNLOCKED)
                  mode_nxt = (in_tuser == KIND_READ) ? MODE_READ : MODE_WRITE;
              end
            end else if (wfull) os_nxt = ST_WAITER_FUL;
            else begin
              wcmd.push = 1'b1;
              wcmd.key_wr = in_tuser[0];
            end
          end else if (in_tuser == KIND_RELEASE) begin
            if (!hhit) begin
              ov_nxt = 1'b0;
              state_nxt = S_PURGE;
            end else begin
              hcmd.remove = 1'b1;
              if (hcount == HCNT_W'(1)) begin
                if (wcount == '0) mode_nxt = MODE_UNLOCKED;
                else begin
                  ov_nxt = 1'b0;
                  ng_nxt = '0;
                  mode_nxt = wwrs[0] ? MODE_WRITE : MODE_READ;
                  state_nxt = S_GRANT;
                end
              end
            end
          end
        end
      end
      S_PURGE: begin
        // One matching waiter squeezed out per cycle.
        if (whit) wcmd.purge = 1'b1;
        else if (out_free) begin
          ov_nxt = 1'b1; od_nxt = '0; og_nxt = 1'b0; ogv_nxt = 1'b0;
          os_nxt = ST_OK; ol_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_GRANT: begin
        if (out_free) begin
          // Move the waiter head to the holder chain and emit it.
          hcmd.push = 1'b1;
          hcmd.key  = wids[0];
          wcmd.shift = 1'b1;
          ov_nxt = 1'b1; od_nxt = wids[0]; og_nxt = 1'b0; ogv_nxt = 1'b1;
          os_nxt = ST_OK;
          ng_nxt = ng_r + BATCH_CW'(1);
          if (mode_r == MODE_WRITE || wcount == WCNT_W'(1) || wwrs[1 % WAITER_SLOTS] ||
              32'(ng_r) + 32'd1 >= 32'(BATCH_LIMIT)) begin
            ol_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else ol_nxt = 1'b0;
        end
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_UNLOCKED;
      ov_r    <= 1'b0;
      ng_r    <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      ov_r    <= ov_nxt;
      ng_r    <= ng_nxt;
    end
    key_r <= key_nxt;
    od_r <= od_nxt; og_r <= og_nxt; ogv_r <= ogv_nxt; os_r <= os_nxt; ol_r <= ol_nxt;
  end

  // Lock mode is reported as it stands after the whole step; for grant
  // bursts the mode is settled on entry, so every beat carries it.
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = {os_r, mode_r, ogv_r, og_r};
  assign out_tlast  = ol_r;

  // Write mode never has more than one holder.
  a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_WRITE) |-> (hcount <= HCNT_W'(1)))
    else $error("write mode with several holders");

  // Unlocked in the idle state means no holders.
  a_unlocked_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_UNLOCKED && state_r == S_IDLE) |-> (hcount == '0))
    else $error("unlocked with holders");

  // A beat with a valid grantee always has ok status and granted_now low.
  a_grant_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ogv_r) |-> (os_r == ST_OK && !og_r))
    else $error("malformed grant beat");
endmodule

// File: sv/rwlq_cell.sv
// ============================================================================
// rwlq_cell: one slot of a holder or waiter chain
// Holds an identifier and a write flag, loads from its right neighbor or a pushed key.
// ============================================================================
module rwlq_cell (
  input  logic                clk,
  input  logic                load,
  input  logic [31:0]         id_in,
  input  logic                wr_in,
  output logic [31:0]         id_q,
  output logic                wr_q
);
  logic [31:0] id_r;
  logic        wr_r;

  always_ff @(posedge clk) begin
    if (load) begin
      id_r <= id_in;
      wr_r <= wr_in;
    end
  end

  assign id_q = id_r;
  assign wr_q = wr_r;
endmodule

// File: sv/rwlq_chain.sv
// ============================================================================
// rwlq_chain: a row of slot cells with per-cell load and source selection
// Supports append, shift by one, removal of the first match, and a purge
// that squeezes out one match per cycle.
// ============================================================================
module rwlq_chain (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  rwlq_pkg::chain_cmd_t                         cmd,
  output logic [rwlq_pkg::CHAIN_CW-1:0]                count,
  output logic [rwlq_pkg::CHAIN_SLOTS-1:0][31:0]       ids,
  output logic [rwlq_pkg::CHAIN_SLOTS-1:0]             wrs,
  output logic                                         hit,      // some valid cell matches key
  output logic                                         full
);
  import rwlq_pkg::*;

  logic [CHAIN_CW-1:0]    count_r, count_nxt;
  logic [CHAIN_SLOTS-1:0] match, below;
  logic [CHAIN_SLOTS-1:0] load;
  logic [CHAIN_SLOTS-1:0][31:0] id_in;
  logic [CHAIN_SLOTS-1:0] wr_in;

  always_comb begin
    for (int i = 0; i < CHAIN_SLOTS; i++) begin
      match[i] = (CHAIN_CW'(i) < count_r) && (ids[i] == cmd.key);
    end
    hit = |match;
    // below[i]: a match exists at some index <= i
    below[0] = match[0];
    for (int i = 1; i < CHAIN_SLOTS; i++) below[i] = below[i-1] | match[i];
  end

  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < CHAIN_SLOTS; i++) begin
      load[i]  = 1'b0;
      id_in[i] = cmd.key;
      wr_in[i] = cmd.key_wr;
      if (i + 1 < CHAIN_SLOTS) begin
        id_in[i] = ids[(i + 1) % CHAIN_SLOTS];
        wr_in[i] = wrs[(i + 1) % CHAIN_SLOTS];
      end
    end
    if (cmd.push) begin
      for (int i = 0; i < CHAIN_SLOTS; i++) begin
        if (CHAIN_CW'(i) == count_r) begin
          load[i]  = 1'b1;
          id_in[i] = cmd.key;
          wr_in[i] = cmd.key_wr;
        end
      end
      count_nxt = count_r + CHAIN_CW'(1);
    end else if (cmd.shift) begin
      load = '1;
      count_nxt = count_r - CHAIN_CW'(1);
    end else if ((cmd.remove || cmd.purge) && hit) begin
      load = below;
      count_nxt = count_r - CHAIN_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else        count_r <= count_nxt;
  end

  for (genvar g = 0; g < CHAIN_SLOTS; g++) begin : g_cell
    rwlq_cell u_cell (
      .clk   (clk),
      .load  (load[g]),
      .id_in (id_in[g]),
      .wr_in (wr_in[g]),
      .id_q  (ids[g]),
      .wr_q  (wrs[g])
    );
  end

  assign count = count_r;
  assign full  = (count_r == CHAIN_CW'(CHAIN_SLOTS));
endmodule
